FILE: hw/rtl/cst_pkg.sv
package cst_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned AddrW      = 48;
  localparam int unsigned FnW        = 5;
  localparam int unsigned CntW       = 64;
  localparam int unsigned StatW      = 3;

  localparam logic [StatW-1:0] StNew      = 3'd0;
  localparam logic [StatW-1:0] StIncr     = 3'd1;
  localparam logic [StatW-1:0] StFull     = 3'd2;
  localparam logic [StatW-1:0] StExtract  = 3'd3;
  localparam logic [StatW-1:0] StEmpty    = 3'd4;
  localparam logic [StatW-1:0] StDisabled = 3'd5;

  localparam logic CmdCount   = 1'b0;
  localparam logic CmdExtract = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0] outer_key;
    logic [AddrW-1:0] middle_key;
    logic [AddrW-1:0] inner_key;
    logic [FnW-1:0]   func;
  } key_t;

  typedef struct packed {
    key_t            key;
    logic [CntW-1:0] calls;
  } slot_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdxW-1:0]  slot_index;
    logic [CntW-1:0]  site_count;
    key_t             found;
  } result_t;

  // Memory access request from the controller
  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    slot_t           wr_data;
  } mem_req_t;

endpackage

FILE: hw/rtl/cst_if.sv
interface cst_in_if;
  import cst_pkg::*;
  logic             valid;
  logic             ready;
  logic             command;
  logic [AddrW-1:0] chain_outer;
  logic [AddrW-1:0] chain_middle;
  logic [AddrW-1:0] chain_inner;
  logic [FnW-1:0]   function_id;
  modport source (output valid, command, chain_outer, chain_middle, chain_inner,
                  function_id, input ready);
  modport sink (input valid, command, chain_outer, chain_middle, chain_inner,
                function_id, output ready);
endinterface

interface cst_out_if;
  import cst_pkg::*;
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [IdxW-1:0]  slot_index;
  logic [CntW-1:0]  site_count;
  logic [AddrW-1:0] found_outer;
  logic [AddrW-1:0] found_middle;
  logic [AddrW-1:0] found_inner;
  logic [FnW-1:0]   found_function;
  modport source (output valid, status, slot_index, site_count, found_outer,
                  found_middle, found_inner, found_function, input ready);
  modport sink (input valid, status, slot_index, site_count, found_outer,
                found_middle, found_inner, found_function, output ready);
endinterface

interface cst_cfg_if;
  logic valid;
  logic ready;
  logic census_enable;
  modport source (output valid, census_enable, input ready);
  modport sink (input valid, census_enable, output ready);
endinterface

FILE: hw/rtl/cst_hash.sv
// Registered hash: ((a*31+b)*31+c) mod depth, on shifted addresses; a*31+b and c are registered.
module cst_hash import cst_pkg::*; (
  input  logic             clk_i,
  input  logic [AddrW-1:0] a_i,
  input  logic [AddrW-1:0] b_i,
  input  logic [AddrW-1:0] c_i,
  output logic [IdxW-1:0]  hash_o
);
  // Only low index bits matter, so arithmetic stays IdxW wide.
  logic [IdxW-1:0] h1_q, c_q;
  logic [IdxW-1:0] h1_d;

  assign h1_d = IdxW'(a_i >> 4) * IdxW'(31) + IdxW'(b_i >> 4);

  always_ff @(posedge clk_i) begin
    h1_q <= h1_d;
    c_q  <= IdxW'(c_i >> 4);
  end

  assign hash_o = h1_q * IdxW'(31) + c_q;
endmodule

FILE: hw/rtl/cst_mem.sv
// Slot store: keys and counts, one read and one write port, registered read.
module cst_mem import cst_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output slot_t    rd_data_o
);
  slot_t mem_q [TableDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr];
    end
  end
endmodule

FILE: hw/rtl/cst_ctrl.sv
// Sequencer: clearing pass, probe walk and extract scan over the slot store.
module cst_ctrl import cst_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  cst_in_if.sink        in_if,
  input  logic          enable_i,
  input  logic [IdxW-1:0] hash_i,
  input  slot_t         rd_data_i,
  output mem_req_t      mem_req_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output result_t       res_o
);
  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SHash  = 3'd2;
  localparam logic [2:0] SProbe = 3'd3;
  localparam logic [2:0] SScan  = 3'd4;
  localparam logic [2:0] SClr   = 3'd5;
  localparam logic [2:0] SOut   = 3'd6;

  localparam logic [CntW-1:0] CntMax = '1;

  logic [2:0]      state_q, state_d;
  logic [IdxW:0]   cnt_q, cnt_d;      // slots visited so far
  logic [IdxW-1:0] addr_q, addr_d;    // address of data arriving now
  logic            rd_pend_q, rd_pend_d;
  key_t            key_q, key_d;
  logic            have_q, have_d;
  logic [IdxW-1:0] best_q, best_d;
  slot_t           best_slot_q, best_slot_d;
  result_t         res_q, res_d;
  logic            res_valid_q, res_valid_d;

  logic [IdxW-1:0] next_addr;
  logic            key_hit;

  assign next_addr = addr_q + IdxW'(1);
  assign key_hit   = (rd_data_i.key == key_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    rd_pend_d   = 1'b0;
    key_d       = key_q;
    have_d      = have_q;
    best_d      = best_q;
    best_slot_d = best_slot_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    mem_req_o   = '0;
    in_if.ready = 1'b0;

    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      // Zero every slot once after reset
      SClear: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = addr_q;
        addr_d = next_addr;
        if (addr_q == '1) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        in_if.ready = !res_valid_q;
        if (in_if.valid && !res_valid_q) begin
          key_d = '{in_if.chain_outer, in_if.chain_middle, in_if.chain_inner,
                    in_if.function_id};
          res_d = '0;
          cnt_d = '0;
          if (in_if.command == CmdExtract) begin
            have_d          = 1'b0;
            mem_req_o.rd_en = 1'b1;
            mem_req_o.rd_addr = '0;
            addr_d    = '0;
            rd_pend_d = 1'b1;
            state_d   = SScan;
          end else if (!enable_i) begin
            res_d.status = StDisabled;
            res_valid_d  = 1'b1;
          end else begin
            state_d = SHash;
          end
        end
      end
      SHash: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = hash_i;
        addr_d    = hash_i;
        rd_pend_d = 1'b1;
        state_d   = SProbe;
      end
      // Each slot: read, then decide once its data has arrived
      SProbe: begin
        if (!rd_pend_q) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = addr_q;
          rd_pend_d = 1'b1;
        end else if (rd_data_i.calls == '0) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = addr_q;
          mem_req_o.wr_data = '{key_q, CntW'(1)};
          res_d.status     = StNew;
          res_d.slot_index = addr_q;
          res_d.site_count = CntW'(1);
          state_d = SOut;
        end else if (key_hit) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = addr_q;
          mem_req_o.wr_data.key   = key_q;
          mem_req_o.wr_data.calls = (rd_data_i.calls == CntMax) ? CntMax
                                    : rd_data_i.calls + CntW'(1);
          res_d.status     = StIncr;
          res_d.slot_index = addr_q;
          res_d.site_count = mem_req_o.wr_data.calls;
          state_d = SOut;
        end else if (cnt_q == (IdxW+1)'(TableDepth - 1)) begin
          res_d.status = StFull;
          state_d = SOut;
        end else begin
          cnt_d  = cnt_q + (IdxW+1)'(1);
          addr_d = next_addr;
        end
      end
      // Pipelined scan: issue read of next slot while comparing this one
      SScan: begin
        if (rd_data_i.calls != '0 &&
            (!have_q || rd_data_i.calls > best_slot_q.calls)) begin
          have_d      = 1'b1;
          best_d      = addr_q;
          best_slot_d = rd_data_i;
        end
        if (addr_q == '1) begin
          state_d = SClr;
        end else begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = next_addr;
          addr_d = next_addr;
        end
      end
      SClr: begin
        if (have_q) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = best_q;
          mem_req_o.wr_data = '{best_slot_q.key, CntW'(0)};
          res_d.status     = StExtract;
          res_d.slot_index = best_q;
          res_d.site_count = best_slot_q.calls;
          res_d.found      = best_slot_q.key;
        end else begin
          res_d.status = StEmpty;
        end
        state_d = SOut;
      end
      SOut: begin
        res_valid_d = 1'b1;
        state_d     = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      addr_q      <= '0;
      res_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      have_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      res_valid_q <= res_valid_d;
      rd_pend_q   <= rd_pend_d;
      have_q      <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    key_q       <= key_d;
    best_q      <= best_d;
    best_slot_q <= best_slot_d;
    res_q       <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
endmodule

FILE: hw/rtl/call_site_census_table.sv
// Channel | Dir | Content
// in_if   | in  | command, three chain addresses, function id
// out_if  | out | status, slot index, count, keys of extracted slot
// cfg_if  | in  | census_enable
// Count: a hash state, a decide step for the first probed slot, a read and a
// decide step for each further slot, then a state to post the result.
// Extract: a full scan of 4096 slots at one per cycle, set by the single read
// port of the store, then clear and post. After reset a clearing pass over all
// 4096 slots runs before the first request.
// One request in flight; a held result blocks the next request.
module call_site_census_table import cst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cst_in_if.sink    in_if,
  cst_out_if.source out_if,
  cst_cfg_if.sink   cfg_if
);
  logic     enable_q;
  logic [IdxW-1:0] hash;
  slot_t    rd_data;
  mem_req_t mem_req;
  result_t  res;

  // Enable register
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_if.valid) begin
      enable_q <= cfg_if.census_enable;
    end
  end

  cst_hash u_hash (
    .clk_i (clk_i),
    .a_i   (in_if.chain_outer),
    .b_i   (in_if.chain_middle),
    .c_i   (in_if.chain_inner),
    .hash_o(hash)
  );

  cst_mem u_mem (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_data_o(rd_data)
  );

  cst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .enable_i   (enable_q),
    .hash_i     (hash),
    .rd_data_i  (rd_data),
    .mem_req_o  (mem_req),
    .res_valid_o(out_if.valid),
    .res_ready_i(out_if.ready),
    .res_o      (res)
  );

  assign out_if.status         = res.status;
  assign out_if.slot_index     = res.slot_index;
  assign out_if.site_count     = res.site_count;
  assign out_if.found_outer    = res.found.outer_key;
  assign out_if.found_middle   = res.found.middle_key;
  assign out_if.found_inner    = res.found.inner_key;
  assign out_if.found_function = res.found.func;
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cst_pkg::*;

  localparam int unsigned CycleLimit = 10000000;
  localparam int unsigned TailCycles = 64;
  localparam int unsigned PoolSize   = 24;

  logic clk_i;
  logic rst_ni;

  cst_in_if  in_if ();
  cst_out_if out_if ();
  cst_cfg_if cfg_if ();

  call_site_census_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Shadow copy of the slot store and the enable register
  key_t            shadow_key   [TableDepth];
  logic [CntW-1:0] shadow_calls [TableDepth];
  logic            shadow_enable;

  result_t pending_results[$];
  key_t    site_pool[PoolSize];
  int      error_count;
  int      cycle_count;
  int      out_stall;
  bit      quiet;

  // Clock and cycle limit
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Start index of the probe sequence for a chain
  function automatic logic [IdxW-1:0] census_slot_of(key_t k);
    logic [63:0] h;
    h = 64'(k.outer_key >> 4) * 64'd31 + 64'(k.middle_key >> 4);
    h = h * 64'd31 + 64'(k.inner_key >> 4);
    return h[IdxW-1:0];
  endfunction

  // Expected result of one request; updates the shadow store
  function automatic result_t predict_census(logic cmd, key_t k);
    result_t          r;
    logic [IdxW-1:0]  j;
    logic [IdxW-1:0]  best;
    bit               have;
    r = '0;
    if (cmd == CmdExtract) begin
      have = 1'b0;
      best = '0;
      for (int i = 0; i < TableDepth; i++) begin
        if (shadow_calls[i] != 0 && (!have || shadow_calls[i] > shadow_calls[best])) begin
          best = i[IdxW-1:0];
          have = 1'b1;
        end
      end
      if (!have) begin
        r.status = StEmpty;
      end else begin
        r.status     = StExtract;
        r.slot_index = best;
        r.site_count = shadow_calls[best];
        r.found      = shadow_key[best];
        shadow_calls[best] = '0;
      end
      return r;
    end
    if (!shadow_enable) begin
      r.status = StDisabled;
      return r;
    end
    j = census_slot_of(k);
    for (int i = 0; i < TableDepth; i++) begin
      if (shadow_calls[j] == 0) begin
        shadow_key[j]   = k;
        shadow_calls[j] = CntW'(1);
        r.status     = StNew;
        r.slot_index = j;
        r.site_count = CntW'(1);
        return r;
      end
      if (shadow_key[j] == k) begin
        if (shadow_calls[j] != '1) shadow_calls[j] = shadow_calls[j] + CntW'(1);
        r.status     = StIncr;
        r.slot_index = j;
        r.site_count = shadow_calls[j];
        return r;
      end
      j = j + 1'b1;
    end
    r.status = StFull;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at cycle %0d", field, got, want, cycle_count);
    error_count++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    result_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_if.status), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status)
          report_mismatch("status", 64'(out_if.status), 64'(want.status));
        if (out_if.slot_index !== want.slot_index)
          report_mismatch("slot_index", 64'(out_if.slot_index), 64'(want.slot_index));
        if (out_if.site_count !== want.site_count)
          report_mismatch("site_count", out_if.site_count, want.site_count);
        if (out_if.found_outer !== want.found.outer_key)
          report_mismatch("found_outer", 64'(out_if.found_outer), 64'(want.found.outer_key));
        if (out_if.found_middle !== want.found.middle_key)
          report_mismatch("found_middle", 64'(out_if.found_middle),
                          64'(want.found.middle_key));
        if (out_if.found_inner !== want.found.inner_key)
          report_mismatch("found_inner", 64'(out_if.found_inner), 64'(want.found.inner_key));
        if (out_if.found_function !== want.found.func)
          report_mismatch("found_function", 64'(out_if.found_function),
                          64'(want.found.func));
      end
    end
  end

  // Result side back-pressure in random bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      out_if.ready <= 1'b1;
      out_stall = 0;
    end else if (out_stall > 0) begin
      out_if.ready <= 1'b0;
      out_stall--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      out_stall = $urandom_range(1, 11) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Send one request; valid stays high unless an idle burst follows
  task automatic send_request(logic cmd, key_t k);
    int gap;
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.chain_outer  <= k.outer_key;
    in_if.chain_middle <= k.middle_key;
    in_if.chain_inner  <= k.inner_key;
    in_if.function_id  <= k.func;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_census(cmd, k));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic count_site(key_t k);
    send_request(CmdCount, k);
  endtask

  task automatic extract_top();
    send_request(CmdExtract, '0);
  endtask

  // Wait until every outstanding result has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_enable(logic value);
    drain_results();
    cfg_if.valid         <= 1'b1;
    cfg_if.census_enable <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    shadow_enable = value;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic key_t random_key();
    key_t k;
    k.outer_key  = AddrW'({$urandom, $urandom});
    k.middle_key = AddrW'({$urandom, $urandom});
    k.inner_key  = AddrW'({$urandom, $urandom});
    k.func       = FnW'($urandom_range(0, 31));
    return k;
  endfunction

  function automatic key_t slot_key(int idx, logic [FnW-1:0] fn);
    key_t k;
    k            = '0;
    k.inner_key  = AddrW'(idx) << 4;
    k.func       = fn;
    return k;
  endfunction

  // Counting is ignored while disabled; extraction of an empty table
  task automatic test_disabled();
    count_site('0);
    count_site('1);
    extract_top();
    drain_results();
  endtask

  // New entries, increments, collisions on one start slot, key extremes
  task automatic test_counting();
    key_t k;
    write_enable(1'b1);
    count_site('0);
    count_site('0);
    count_site('1);
    k = '1;
    k.func = 5'd0;
    count_site(k);
    count_site(slot_key(5, 5'd1));
    count_site(slot_key(5, 5'd2));
    k = slot_key(5, 5'd1);
    k.inner_key[3:0] = 4'hf;
    count_site(k);
    count_site(slot_key(5, 5'd2));
    count_site(slot_key(4095, 5'd29));
    count_site(slot_key(4095, 5'd30));
    drain_results();
  endtask

  // Largest first, ties go to the lowest slot, then empty; works while disabled
  task automatic test_extract();
    count_site(slot_key(9, 5'd3));
    count_site(slot_key(9, 5'd3));
    count_site(slot_key(4000, 5'd4));
    count_site(slot_key(4000, 5'd4));
    extract_top();
    write_enable(1'b0);
    count_site(slot_key(9, 5'd3));
    repeat (11) extract_top();
    write_enable(1'b1);
    drain_results();
  endtask

  // Mostly a small pool of hot sites, some fresh keys and extractions
  task automatic test_random_traffic();
    int pick;
    for (int i = 0; i < PoolSize; i++) site_pool[i] = random_key();
    for (int n = 0; n < 420; n++) begin
      if (n > 360) quiet = 1'b1;
      if (n % 100 == 50) write_enable(1'b0);
      if (n % 100 == 65) write_enable(1'b1);
      pick = $urandom_range(0, 99);
      if (pick < 8) extract_top();
      else if (pick < 12) count_site(random_key());
      else count_site(site_pool[$urandom_range(0, PoolSize - 1)]);
    end
    drain_results();
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    out_stall   = 0;
    quiet       = 1'b0;
    shadow_enable = 1'b0;
    for (int i = 0; i < TableDepth; i++) begin
      shadow_calls[i] = '0;
      shadow_key[i]   = '0;
    end
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.command        = CmdCount;
    in_if.chain_outer    = '0;
    in_if.chain_middle   = '0;
    in_if.chain_inner    = '0;
    in_if.function_id    = '0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.census_enable = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled();
    test_counting();
    test_extract();
    test_random_traffic();

    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
